@@ rtl/crc16_command_frame_and_reply_check_unit_assert.svh @@
// assertion macros for the crc16 frame and reply check unit
`ifndef CRC16_COMMAND_FRAME_AND_REPLY_CHECK_UNIT_ASSERT_SVH
`define CRC16_COMMAND_FRAME_AND_REPLY_CHECK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CRC16CF_ASSERT_IMP(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("assertion failed");
`define CRC16CF_ASSERT_NXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define CRC16CF_ASSERT_IMP(label, cond, expr)
`define CRC16CF_ASSERT_NXT(label, cond, expr)
`endif

`endif

@@ rtl/crc16cf_pkg.sv @@
package crc16cf_pkg;

   localparam logic [15:0] CRC_POLY     = 16'h8005;
   localparam logic [7:0]  FRAME_START  = 8'h03;
   localparam logic [7:0]  FRAME_COUNT  = 8'h07;
   localparam int          LEN_W        = 7;
   localparam logic [6:0]  LEN_RESET    = 7'd7;
   localparam logic [6:0]  LEN_MIN      = 7'd4;
   localparam logic [6:0]  LEN_MAX      = 7'd64;
   localparam logic [6:0]  SEEN_MAX     = 7'd127;
   localparam int          QUEUE_DEPTH  = 4;
   localparam int          QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int          QUEUE_CW     = QUEUE_AW + 1;

   localparam logic ACTION_BUILD = 1'b0;
   localparam logic ACTION_REPLY = 1'b1;
   localparam logic KIND_FRAME   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_LENGTH = 2'd1,
      STATUS_CRC    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      IDX_START  = 3'd0,
      IDX_COUNT  = 3'd1,
      IDX_OPCODE = 3'd2,
      IDX_PARAM1 = 3'd3,
      IDX_P2_LO  = 3'd4,
      IDX_P2_HI  = 3'd5,
      IDX_CRC_LO = 3'd6,
      IDX_CRC_HI = 3'd7
   } frame_idx_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  opcode;
      logic [7:0]  param_first;
      logic [15:0] param_second;
      status_type  status;
   } entry_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (data[i] != c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/crc16cf_req_if.sv @@
interface crc16cf_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  opcode;
   logic [7:0]  param_first;
   logic [15:0] param_second;
   logic [7:0]  reply_byte;
   logic        reply_last;

   modport source (output valid, action, opcode, param_first, param_second, reply_byte,
                   reply_last, input ready);
   modport sink (input valid, action, opcode, param_first, param_second, reply_byte,
                 reply_last, output ready);
endinterface

@@ rtl/crc16cf_rsp_if.sv @@
interface crc16cf_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] frame_byte;
   logic       frame_last;
   logic [1:0] status;

   modport source (output valid, kind, frame_byte, frame_last, status, input ready);
   modport sink (input valid, kind, frame_byte, frame_last, status, output ready);
endinterface

@@ rtl/crc16cf_csr_if.sv @@
interface crc16cf_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ rtl/crc16_command_frame_and_reply_check_unit.sv @@
// the first result word of a request passes through the queue and then the output register
// reply bytes: one word per cycle while the queue is not full; a non-final byte gives no result
// command frame: eight result words, one per cycle while the result side is ready, set by the frame byte sequencer
// a four-entry queue lets requests keep coming while a frame drains
// synchronous active-high reset: reply length 7, reply check state and queue cleared
`include "crc16_command_frame_and_reply_check_unit_assert.svh"

module crc16_command_frame_and_reply_check_unit
   import crc16cf_pkg::*;
(
   input  logic clock,
   input  logic reset,
   crc16cf_req_if.sink   req_ch,
   crc16cf_rsp_if.source rsp_ch,
   crc16cf_csr_if.sink   csr_ch
);

   logic      q_push;
   entry_type q_push_entry;
   logic      q_full;
   logic      q_pop;
   logic      q_head_valid;
   entry_type q_head;

   crc16cf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (q_full),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   crc16cf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   crc16cf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_ch     (rsp_ch)
   );

   `CRC16CF_ASSERT_IMP(a_pop_has_entry, q_pop, q_head_valid)
   `CRC16CF_ASSERT_IMP(a_verdict_shape, rsp_ch.valid && rsp_ch.kind == KIND_VERDICT, rsp_ch.frame_last && rsp_ch.frame_byte == 8'd0)
   `CRC16CF_ASSERT_IMP(a_frame_status_ok, rsp_ch.valid && rsp_ch.kind == KIND_FRAME, rsp_ch.status == STATUS_OK)
   `CRC16CF_ASSERT_NXT(a_push_fills_queue, q_push && !q_pop, q_head_valid)

endmodule

@@ rtl/crc16cf_queue.sv @@
module crc16cf_queue
   import crc16cf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head
);

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]     count_ff, count_in;

   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/crc16cf_front.sv @@
module crc16cf_front
   import crc16cf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   crc16cf_req_if.sink req_ch,
   crc16cf_csr_if.sink csr_ch,
   input  logic      queue_full,
   output logic      push,
   output entry_type push_entry
);

   logic [LEN_W-1:0] len_ff;
   logic [15:0]      crc_ff, crc_in;
   logic [LEN_W-1:0] seen_ff, seen_in;
   logic             count_ok_ff, count_ok_in;
   logic             low_ok_ff, low_ok_in;

   logic             accept;
   logic             len_ok;
   logic             high_ok;
   logic [LEN_W-1:0] len_less2;
   logic [LEN_W-1:0] len_less1;
   logic [LEN_W:0]   pos_next;
   status_type       verdict;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;

   assign len_ok    = (len_ff >= LEN_MIN) && (len_ff <= LEN_MAX);
   assign len_less2 = len_ff - LEN_W'(2);
   assign len_less1 = len_ff - LEN_W'(1);
   assign pos_next  = {1'b0, seen_ff} + (LEN_W+1)'(1);

   always_comb begin
      crc_in      = crc_ff;
      seen_in     = seen_ff;
      count_ok_in = count_ok_ff;
      low_ok_in   = low_ok_ff;
      high_ok     = 1'b1;
      verdict     = STATUS_OK;
      push        = 1'b0;

      push_entry.kind         = KIND_FRAME;
      push_entry.opcode       = req_ch.opcode;
      push_entry.param_first  = req_ch.param_first;
      push_entry.param_second = req_ch.param_second;
      push_entry.status       = STATUS_OK;

      if (accept && req_ch.action == ACTION_BUILD) begin
         push = 1'b1;
      end else if (accept) begin
         if (len_ok) begin
            if (seen_ff == '0 && req_ch.reply_byte != {1'b0, len_ff}) begin
               count_ok_in = 1'b0;
            end
            if (seen_ff < len_less2) begin
               crc_in = crc_feed(crc_ff, req_ch.reply_byte);
            end else if (seen_ff == len_less2) begin
               if (req_ch.reply_byte != crc_ff[7:0]) begin
                  low_ok_in = 1'b0;
               end
            end else if (seen_ff == len_less1) begin
               high_ok = (req_ch.reply_byte == crc_ff[15:8]);
            end
         end
         if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + 1'b1;
         end

         if (!len_ok || pos_next != {1'b0, len_ff} || !count_ok_in) begin
            verdict = STATUS_LENGTH;
         end else if (!low_ok_in || !high_ok) begin
            verdict = STATUS_CRC;
         end

         if (req_ch.reply_last) begin
            push              = 1'b1;
            push_entry.kind   = KIND_VERDICT;
            push_entry.status = verdict;
            crc_in            = '0;
            seen_in           = '0;
            count_ok_in       = 1'b1;
            low_ok_in         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= LEN_RESET;
         crc_ff      <= '0;
         seen_ff     <= '0;
         count_ok_ff <= 1'b1;
         low_ok_ff   <= 1'b1;
      end else begin
         if (csr_ch.valid) begin
            len_ff <= csr_ch.data;
         end
         crc_ff      <= crc_in;
         seen_ff     <= seen_in;
         count_ok_ff <= count_ok_in;
         low_ok_ff   <= low_ok_in;
      end
   end

endmodule

@@ rtl/crc16cf_back.sv @@
module crc16cf_back
   import crc16cf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head,
   output logic      pop,
   crc16cf_rsp_if.source rsp_ch
);

   frame_idx_type idx_ff, idx_in;
   logic [15:0]   crc_ff, crc_in;
   logic          valid_ff, valid_in;
   logic          kind_ff, kind_in;
   logic [7:0]    byte_ff, byte_in;
   logic          last_ff, last_in;
   status_type    status_ff, status_in;

   logic          emit;
   logic [15:0]   crc_base;

   assign emit     = head_valid && (!valid_ff || rsp_ch.ready);
   assign crc_base = (idx_ff == IDX_START) ? '0 : crc_ff;

   always_comb begin
      unique case (idx_ff)
         IDX_START:  byte_in = FRAME_START;
         IDX_COUNT:  byte_in = FRAME_COUNT;
         IDX_OPCODE: byte_in = head.opcode;
         IDX_PARAM1: byte_in = head.param_first;
         IDX_P2_LO:  byte_in = head.param_second[7:0];
         IDX_P2_HI:  byte_in = head.param_second[15:8];
         IDX_CRC_LO: byte_in = crc_ff[7:0];
         IDX_CRC_HI: byte_in = crc_ff[15:8];
         default:    byte_in = '0;
      endcase

      kind_in   = head.kind;
      last_in   = (idx_ff == IDX_CRC_HI);
      status_in = STATUS_OK;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      pop       = 1'b0;

      if (head.kind == KIND_VERDICT) begin
         byte_in   = '0;
         last_in   = 1'b1;
         status_in = head.status;
         pop       = emit;
      end else if (emit) begin
         idx_in = frame_idx_type'(idx_ff + 3'd1);
         pop    = (idx_ff == IDX_CRC_HI);
         case (idx_ff) inside
            IDX_COUNT, IDX_OPCODE, IDX_PARAM1, IDX_P2_LO, IDX_P2_HI:
               crc_in = crc_feed(crc_base, byte_in);
            default:
               crc_in = crc_base;
         endcase
      end

      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= IDX_START;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (emit) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         last_ff   <= last_in;
         status_ff <= status_in;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.kind       = kind_ff;
   assign rsp_ch.frame_byte = byte_ff;
   assign rsp_ch.frame_last = last_ff;
   assign rsp_ch.status     = status_ff;

endmodule

@@ dv/tb.sv @@
module tb;
   import crc16cf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        action;
      logic [7:0]  opcode;
      logic [7:0]  param_first;
      logic [15:0] param_second;
      logic [7:0]  reply_byte;
      logic        reply_last;
   } link_req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] frame_byte;
      logic       frame_last;
      logic [1:0] status;
   } link_word_type;

   typedef enum int {
      REPLY_GOOD,
      REPLY_BAD_COUNT,
      REPLY_BAD_CRC_LO,
      REPLY_BAD_CRC_HI,
      REPLY_BAD_BOTH,
      REPLY_SHORT,
      REPLY_LONG
   } reply_shape_type;

   logic clock;
   logic reset;

   crc16cf_req_if req_bus ();
   crc16cf_rsp_if rsp_bus ();
   crc16cf_csr_if csr_bus ();

   crc16_command_frame_and_reply_check_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // predictor state
   logic [6:0]  reply_len   = LEN_RESET;
   logic [15:0] reply_crc   = '0;
   logic [6:0]  reply_seen  = '0;
   logic        count_good  = 1'b1;
   logic        crc_lo_good = 1'b1;

   link_req_type  send_q[$];
   link_word_type pending_words[$];
   logic [7:0]    reply_bytes[$];

   bit idle_on = 1'b1;
   int errors = 0;
   int words_sent = 0;
   int frames_built = 0;
   int verdicts_seen = 0;
   int csr_writes = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [15:0] crc16_shift_byte(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int k = 0; k < 8; k++) begin
         fb = d[k] ^ r[15];
         r  = r << 1;
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   function automatic void predict_words(input link_req_type it);
      logic [7:0]  f[8];
      logic [15:0] c;
      logic [6:0]  len;
      logic [6:0]  pos;
      logic        len_ok;
      logic        high_ok;
      status_type  st;
      if (it.action == ACTION_BUILD) begin
         f[0] = FRAME_START;
         f[1] = FRAME_COUNT;
         f[2] = it.opcode;
         f[3] = it.param_first;
         f[4] = it.param_second[7:0];
         f[5] = it.param_second[15:8];
         c = '0;
         for (int i = 1; i <= 5; i++) c = crc16_shift_byte(c, f[i]);
         f[6] = c[7:0];
         f[7] = c[15:8];
         for (int i = 0; i < 8; i++)
            pending_words.push_back('{KIND_FRAME, f[i], (i == 7), STATUS_OK});
         frames_built++;
      end else begin
         len     = reply_len;
         pos     = reply_seen;
         len_ok  = (len >= LEN_MIN) && (len <= LEN_MAX);
         high_ok = 1'b1;
         if (len_ok) begin
            if (pos == 0 && it.reply_byte != {1'b0, len}) count_good = 1'b0;
            if (pos < len - 2) begin
               reply_crc = crc16_shift_byte(reply_crc, it.reply_byte);
            end else if (pos == len - 2) begin
               if (it.reply_byte != reply_crc[7:0]) crc_lo_good = 1'b0;
            end else if (pos == len - 1) begin
               high_ok = (it.reply_byte == reply_crc[15:8]);
            end
         end
         if (reply_seen != SEEN_MAX) reply_seen++;
         if (it.reply_last) begin
            if (!len_ok || pos + 1 != len || !count_good) st = STATUS_LENGTH;
            else if (!crc_lo_good || !high_ok) st = STATUS_CRC;
            else st = STATUS_OK;
            pending_words.push_back('{KIND_VERDICT, 8'h00, 1'b1, st});
            reply_crc   = '0;
            reply_seen  = '0;
            count_good  = 1'b1;
            crc_lo_good = 1'b1;
         end
      end
   endfunction

   // request driver: bursts with random gaps, valid held until taken
   initial begin : req_driver
      int burst_left;
      int gap_left;
      burst_left = 4;
      gap_left = 0;
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACTION_BUILD;
      req_bus.opcode       <= '0;
      req_bus.param_first  <= '0;
      req_bus.param_second <= '0;
      req_bus.reply_byte   <= '0;
      req_bus.reply_last   <= 1'b0;
      forever begin
         @(posedge clock);
         if (req_bus.valid && req_bus.ready) begin
            predict_words(send_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = idle_on ? $urandom_range(1, 6) : 0;
            end
         end
         if (!reset && gap_left == 0 && send_q.size() != 0) begin
            req_bus.valid        <= 1'b1;
            req_bus.action       <= send_q[0].action;
            req_bus.opcode       <= send_q[0].opcode;
            req_bus.param_first  <= send_q[0].param_first;
            req_bus.param_second <= send_q[0].param_second;
            req_bus.reply_byte   <= send_q[0].reply_byte;
            req_bus.reply_last   <= send_q[0].reply_last;
         end else begin
            req_bus.valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // result stall pattern
   initial begin : rsp_stall
      int tick;
      tick = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         case ((tick / 97) % 4)
            0: begin
               rsp_bus.ready <= 1'b1;
            end
            1: begin
               rsp_bus.ready <= tick[0];
            end
            2: begin
               rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_bus.ready <= ((tick % 13) < 5);
            end
         endcase
      end
   end

   initial begin : word_checker
      link_word_type got;
      link_word_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.kind, rsp_bus.frame_byte, rsp_bus.frame_last, rsp_bus.status};
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = pending_words.pop_front();
               if (got.kind != want.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                  errors++;
               end
               if (got.frame_byte != want.frame_byte) begin
                  $display("%0t: frame_byte expected %h actual %h", $time,
                           want.frame_byte, got.frame_byte);
                  errors++;
               end
               if (got.frame_last != want.frame_last) begin
                  $display("%0t: frame_last expected %0d actual %0d", $time,
                           want.frame_last, got.frame_last);
                  errors++;
               end
               if (got.status != want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, got.status);
                  errors++;
               end
               if (want.kind == KIND_VERDICT) verdicts_seen++;
            end
         end
      end
   end

   task automatic push_word(input link_req_type it);
      while (send_q.size() >= 4) @(posedge clock);
      send_q.push_back(it);
      words_sent++;
   endtask

   task automatic send_build(input logic [7:0] op, input logic [7:0] pa, input logic [15:0] pb);
      link_req_type it;
      it.action       = ACTION_BUILD;
      it.opcode       = op;
      it.param_first  = pa;
      it.param_second = pb;
      it.reply_byte   = 8'($urandom);
      it.reply_last   = 1'($urandom);
      push_word(it);
   endtask

   task automatic send_random_build();
      send_build(8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic send_reply_byte(input logic [7:0] b, input logic last);
      link_req_type it;
      it.action       = ACTION_REPLY;
      it.opcode       = 8'($urandom);
      it.param_first  = 8'($urandom);
      it.param_second = 16'($urandom);
      it.reply_byte   = b;
      it.reply_last   = last;
      push_word(it);
   endtask

   // fills reply_bytes with an n byte reply, then applies the requested damage
   function automatic void build_reply(input int n, input reply_shape_type shape);
      logic [15:0] c;
      reply_bytes.delete();
      reply_bytes.push_back(n[7:0]);
      for (int i = 1; i <= n - 3; i++) reply_bytes.push_back(8'($urandom));
      c = '0;
      foreach (reply_bytes[i]) c = crc16_shift_byte(c, reply_bytes[i]);
      reply_bytes.push_back(c[7:0]);
      reply_bytes.push_back(c[15:8]);
      case (shape)
         REPLY_BAD_COUNT: begin
            reply_bytes[0] ^= 8'($urandom_range(1, 255));
         end
         REPLY_BAD_CRC_LO: begin
            reply_bytes[n - 2] ^= 8'($urandom_range(1, 255));
         end
         REPLY_BAD_CRC_HI: begin
            reply_bytes[n - 1] ^= 8'($urandom_range(1, 255));
         end
         REPLY_BAD_BOTH: begin
            reply_bytes[0] ^= 8'($urandom_range(1, 255));
            reply_bytes[n - 1] ^= 8'($urandom_range(1, 255));
         end
         REPLY_SHORT: begin
            void'(reply_bytes.pop_back());
         end
         REPLY_LONG: begin
            repeat ($urandom_range(1, 3)) reply_bytes.push_back(8'($urandom));
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_bytes(input int from, input int upto, input bit mid_build);
      for (int i = from; i < upto; i++) begin
         if (mid_build && i == reply_bytes.size() / 2) send_random_build();
         send_reply_byte(reply_bytes[i], (i == reply_bytes.size() - 1));
      end
   endtask

   task automatic send_reply(input int n, input reply_shape_type shape, input bit mid_build);
      build_reply(n, shape);
      send_bytes(0, reply_bytes.size(), mid_build);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (send_q.size() != 0 || req_bus.valid || pending_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reply_length(input logic [6:0] v);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock);
      while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      reply_len = v;
      csr_writes++;
   endtask

   task automatic test_frame_build();
      send_build(8'h00, 8'h00, 16'h0000);
      send_build(8'hff, 8'hff, 16'hffff);
      send_build(8'h5a, 8'ha5, 16'h0ff0);
   endtask

   task automatic test_reply_verdicts();
      send_reply(7, REPLY_GOOD, 1'b0);
      write_reply_length(LEN_MIN);
      send_reply(4, REPLY_BAD_CRC_HI, 1'b0);
      send_reply(4, REPLY_BAD_BOTH, 1'b0);
      send_reply(4, REPLY_SHORT, 1'b0);
      send_reply(4, REPLY_LONG, 1'b0);
   endtask

   task automatic test_register_range();
      write_reply_length(7'd3);
      send_reply(4, REPLY_GOOD, 1'b0);
      write_reply_length(7'd65);
      send_reply(5, REPLY_GOOD, 1'b0);
   endtask

   // reply state must survive a register write between bytes
   task automatic test_write_mid_reply();
      write_reply_length(7'd5);
      build_reply(5, REPLY_GOOD);
      send_bytes(0, 3, 1'b0);
      write_reply_length(7'd5);
      send_bytes(3, 5, 1'b0);
      build_reply(5, REPLY_GOOD);
      send_bytes(0, 2, 1'b0);
      write_reply_length(7'd6);
      send_bytes(2, 5, 1'b0);
   endtask

   task automatic test_build_mid_reply();
      write_reply_length(LEN_MIN);
      send_reply(4, REPLY_GOOD, 1'b1);
   endtask

   task automatic test_random_traffic();
      logic [6:0] settings[8];
      int start;
      int n;
      int r;
      settings[0] = LEN_MIN;
      settings[1] = 7'($urandom_range(5, 12));
      settings[2] = 7'd0;
      settings[3] = LEN_MAX;
      settings[4] = 7'($urandom_range(5, 20));
      settings[5] = 7'd127;
      settings[6] = 7'($urandom_range(5, 10));
      settings[7] = LEN_RESET;
      for (int p = 0; p < 8; p++) begin
         write_reply_length(settings[p]);
         idle_on = (p % 3 != 1);
         start = words_sent;
         while (words_sent - start < 25) begin
            if (settings[p] >= LEN_MIN && settings[p] <= LEN_MAX) n = settings[p];
            else n = $urandom_range(4, 10);
            r = $urandom_range(0, 99);
            if (r < 20) begin
               send_random_build();
            end else if (r < 68) begin
               send_reply(n, REPLY_GOOD, 1'b0);
            end else if (r < 76) begin
               send_reply(n, REPLY_GOOD, 1'b1);
            end else if (r < 96) begin
               send_reply(n, reply_shape_type'($urandom_range(1, 6)),
                          1'($urandom_range(0, 1)));
            end else begin
               send_reply_byte(8'($urandom), 1'($urandom));
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // a long run of bytes drives the byte counter into saturation
   task automatic test_count_saturation();
      write_reply_length(LEN_MIN);
      for (int i = 0; i < 130; i++) send_reply_byte(8'($urandom), (i == 129));
      send_reply(4, REPLY_GOOD, 1'b0);
   endtask

   initial begin
      reset         <= 1'b1;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_frame_build();
      test_reply_verdicts();
      test_register_range();
      test_write_mid_reply();
      test_build_mid_reply();
      test_random_traffic();
      test_count_saturation();

      wait_idle();
      repeat (10) @(posedge clock);
      if (pending_words.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, pending_words.size());
         errors++;
      end
      $display("Ran %0d request words: %0d command frames and %0d reply verdicts checked,",
               words_sent, frames_built, verdicts_seen);
      $display("over %0d reply length writes including out of range values", csr_writes);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
